### hw/rtl/block_assembly_window_macros.svh
// Assertion macros shared by the block assembly window design.
`ifndef BLOCK_ASSEMBLY_WINDOW_MACROS_SVH
`define BLOCK_ASSEMBLY_WINDOW_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BAW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BAW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/blkaw_pkg.sv
// Types and constants shared by the block assembly window modules.
package blkaw_pkg;

  localparam int WINDOW_DEF       = 8;
  localparam int MAX_SUBBANDS_DEF = 512;

  typedef enum logic [1:0] {
    KIND_EMIT = 2'd0,
    KIND_DROP = 2'd1,
    KIND_EOS  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_NUM_SUBBANDS  = 2'd0;
  localparam logic [1:0] REG_NUM_BLOCKS    = 2'd1;
  localparam logic [1:0] REG_MAX_IN_FLIGHT = 2'd2;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [9:0]  num_subbands;
    logic [31:0] num_blocks;
    logic [3:0]  max_in_flight;
  } cfg_t;

  typedef struct packed {
    logic        flush;
    logic [31:0] blk;
    logic [8:0]  sb;
    logic        blk_oob;
    logic        sb_bad;
    logic        is_final;
    logic        drop;
    logic [6:0]  limit;
    logic [9:0]  ns;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] blk;
    logic [9:0]  rc;
    logic [9:0]  lc;
  } res_t;

  typedef struct packed {
    logic       clearing;
    logic [6:0] open_cnt;
  } status_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_LOOK,
    ST_RD,
    ST_MARK,
    ST_SCAN,
    ST_DECIDE,
    ST_FIN
  } back_state_t;

  typedef enum logic [1:0] {
    PUR_FLUSH,
    PUR_EVICT,
    PUR_DONE
  } purpose_t;

endpackage

### hw/rtl/blkaw_if.sv
// Valid/ready channel interfaces for input items and result items.
interface blkaw_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] block_index;
  logic [8:0]  subband_index;
  modport source (output valid, opcode, block_index, subband_index, input ready);
  modport sink (input valid, opcode, block_index, subband_index, output ready);
endinterface

interface blkaw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] out_block;
  logic [9:0]  received_count;
  logic [9:0]  lost_count;
  logic        last;
  modport source (output valid, kind, out_block, received_count, lost_count, last,
                  input ready);
  modport sink (input valid, kind, out_block, received_count, lost_count, last,
                output ready);
endinterface

### hw/rtl/blkaw_cfg.sv
// APB-style configuration registers of the block assembly window.
module blkaw_cfg import blkaw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_NUM_SUBBANDS:  cfg_nxt.num_subbands  = pwdata[9:0];
        REG_NUM_BLOCKS:    cfg_nxt.num_blocks    = pwdata;
        REG_MAX_IN_FLIGHT: cfg_nxt.max_in_flight = pwdata[3:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_SUBBANDS:  prdata = {22'd0, cfg_r.num_subbands};
      REG_NUM_BLOCKS:    prdata = cfg_r.num_blocks;
      REG_MAX_IN_FLIGHT: prdata = {28'd0, cfg_r.max_in_flight};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_subbands  <= 10'd512;
      cfg_r.num_blocks    <= 32'd0;
      cfg_r.max_in_flight <= 4'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hw/rtl/blkaw_front.sv
// Front end: accepts input beats, classifies them and queues them for the engine.
module blkaw_front import blkaw_pkg::*; #(
  parameter int WINDOW       = WINDOW_DEF,
  parameter int MAX_SUBBANDS = MAX_SUBBANDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  blkaw_in_if.sink   in_ch,
  input  cfg_t       cfg,
  input  logic       hold,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      q_mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic [9:0] ns;
  logic [6:0] lim;
  item_t      cls;

  assign in_ch.ready = (cnt_r != 2'd2) && !hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = cnt_r != 2'd0;
  assign q_item      = q_mem_r[rp_r];

  always_comb begin
    if (int'(cfg.num_subbands) > MAX_SUBBANDS) begin
      ns = 10'(MAX_SUBBANDS);
    end else begin
      ns = cfg.num_subbands;
    end
    if (cfg.max_in_flight != 4'd0 && int'(cfg.max_in_flight) < WINDOW) begin
      lim = {3'd0, cfg.max_in_flight};
    end else begin
      lim = 7'(WINDOW);
    end
    cls.flush    = in_ch.opcode == OP_FLUSH;
    cls.blk      = in_ch.block_index;
    cls.sb       = in_ch.subband_index;
    cls.blk_oob  = (cfg.num_blocks != 32'd0) && (in_ch.block_index >= cfg.num_blocks);
    cls.sb_bad   = {1'b0, in_ch.subband_index} >= ns;
    cls.is_final = (cfg.num_blocks != 32'd0) &&
                   (in_ch.block_index == cfg.num_blocks - 32'd1);
    cls.drop     = cfg.max_in_flight != 4'd0;
    cls.limit    = lim;
    cls.ns       = ns;
  end

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cls;
    end
  end

endmodule

### hw/rtl/blkaw_back.sv
// Back end: window bookkeeping, received-subband memory and result output.
module blkaw_back import blkaw_pkg::*; #(
  parameter int WINDOW       = WINDOW_DEF,
  parameter int MAX_SUBBANDS = MAX_SUBBANDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  blkaw_out_if.source out_ch,
  output status_t    status
);

  localparam int DEPTH = WINDOW * MAX_SUBBANDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  back_state_t state_r, state_nxt;
  item_t       item_r, item_nxt;
  purpose_t    pur_r, pur_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   best_r, best_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [WINDOW-1:0] ev_valid_r, ev_valid_nxt;
  logic [31:0]       ev_blk_r [WINDOW];
  logic [31:0]       ev_blk_nxt [WINDOW];
  logic [9:0]        ev_rem_r [WINDOW];
  logic [9:0]        ev_rem_nxt [WINDOW];
  logic [9:0]        ev_rcv_r [WINDOW];
  logic [9:0]        ev_rcv_nxt [WINDOW];
  logic              any_r, any_nxt;
  logic [31:0]       lastb_r, lastb_nxt;

  logic              pend_valid_r, pend_valid_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic [32:0]       mem [DEPTH];
  logic [32:0]       rd_data_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, slot_addr;
  logic [32:0]       mem_wd;

  logic          out_free, can;
  logic          hit, free_found, late;
  logic [SW-1:0] hit_slot, free_slot;
  logic [6:0]    open_cnt;
  logic          look_err, look_hit, look_evict;
  logic [1:0]    look_kind;
  logic          mark_dup, mark_done;
  logic [9:0]    rem_dec;
  logic          dec_emit, dec_eos;
  logic          gen;
  res_t          gen_res;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign can       = !pend_valid_r || out_free;
  assign slot_addr = AW'(int'(slot_r) * MAX_SUBBANDS + int'(item_r.sb));

  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    open_cnt   = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (ev_valid_r[i] && ev_blk_r[i] == item_r.blk) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
      open_cnt = open_cnt + 7'(ev_valid_r[i]);
    end
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!ev_valid_r[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  always_comb begin
    late       = any_r && (item_r.blk <= lastb_r);
    look_err   = 1'b0;
    look_kind  = KIND_ERR;
    look_hit   = 1'b0;
    look_evict = 1'b0;
    if (item_r.blk_oob) begin
      look_err = 1'b1;
    end else if (!hit && late) begin
      look_err  = 1'b1;
      look_kind = item_r.drop ? KIND_DROP : KIND_ERR;
    end else if (item_r.sb_bad) begin
      look_err = 1'b1;
    end else if (hit) begin
      look_hit = 1'b1;
    end else if (open_cnt >= item_r.limit) begin
      if (item_r.drop) begin
        look_evict = 1'b1;
      end else begin
        look_err = 1'b1;
      end
    end else if (!free_found) begin
      look_err = 1'b1;
    end
    mark_dup  = rd_data_r[32] && (rd_data_r[31:0] == item_r.blk);
    rem_dec   = (ev_rem_r[slot_r] != 10'd0) ? ev_rem_r[slot_r] - 10'd1 : 10'd0;
    mark_done = rem_dec == 10'd0;
    dec_emit  = found_r && ((pur_r != PUR_DONE) || (best_r <= item_r.blk));
    dec_eos   = (pur_r == PUR_FLUSH) || ((pur_r == PUR_DONE) && item_r.is_final);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (item_r.flush || look_evict) begin
          state_nxt = ST_SCAN;
        end else if (look_err) begin
          if (can) begin
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_MARK;
      ST_MARK: begin
        if (mark_dup) begin
          if (can) begin
            state_nxt = ST_FIN;
          end
        end else if (mark_done) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (scan_r == SW'(WINDOW - 1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (dec_emit) begin
          if (can) begin
            state_nxt = (pur_r == PUR_EVICT) ? ST_RD : ST_SCAN;
          end
        end else if (dec_eos) begin
          if (can) begin
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt       = item_r;
    pur_nxt        = pur_r;
    slot_nxt       = slot_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    clr_nxt        = clr_r;
    ev_valid_nxt   = ev_valid_r;
    ev_blk_nxt     = ev_blk_r;
    ev_rem_nxt     = ev_rem_r;
    ev_rcv_nxt     = ev_rcv_r;
    any_nxt        = any_r;
    lastb_nxt      = lastb_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wa         = slot_addr;
    mem_wd         = {1'b1, item_r.blk};
    gen            = 1'b0;
    gen_res        = '0;
    case (state_r)
      ST_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
        end
      end
      ST_LOOK: begin
        if (item_r.flush || look_evict) begin
          pur_nxt   = item_r.flush ? PUR_FLUSH : PUR_EVICT;
          scan_nxt  = '0;
          found_nxt = 1'b0;
        end else if (look_err) begin
          gen     = can;
          gen_res = '{kind: look_kind, blk: item_r.blk, rc: 10'd0, lc: 10'd0};
        end else if (look_hit) begin
          slot_nxt = hit_slot;
        end else begin
          slot_nxt                = free_slot;
          ev_valid_nxt[free_slot] = 1'b1;
          ev_blk_nxt[free_slot]   = item_r.blk;
          ev_rem_nxt[free_slot]   = item_r.ns;
          ev_rcv_nxt[free_slot]   = 10'd0;
        end
      end
      ST_RD: mem_re = 1'b1;
      ST_MARK: begin
        if (mark_dup) begin
          gen     = can;
          gen_res = '{kind: KIND_ERR, blk: item_r.blk, rc: 10'd0, lc: 10'd0};
        end else begin
          mem_we             = 1'b1;
          ev_rem_nxt[slot_r] = rem_dec;
          ev_rcv_nxt[slot_r] = ev_rcv_r[slot_r] + 10'd1;
          if (mark_done) begin
            pur_nxt   = PUR_DONE;
            scan_nxt  = '0;
            found_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (ev_valid_r[scan_r] && (!found_r || ev_blk_r[scan_r] < best_r)) begin
          found_nxt = 1'b1;
          best_nxt  = ev_blk_r[scan_r];
          slot_nxt  = scan_r;
        end
        scan_nxt = scan_r + SW'(1);
      end
      ST_DECIDE: begin
        if (dec_emit) begin
          gen     = can;
          gen_res = '{kind: KIND_EMIT, blk: best_r, rc: ev_rcv_r[slot_r],
                      lc: ev_rem_r[slot_r]};
          if (can) begin
            any_nxt   = 1'b1;
            lastb_nxt = best_r;
            scan_nxt  = '0;
            found_nxt = 1'b0;
            if (pur_r == PUR_EVICT) begin
              ev_valid_nxt[slot_r] = 1'b1;
              ev_blk_nxt[slot_r]   = item_r.blk;
              ev_rem_nxt[slot_r]   = item_r.ns;
              ev_rcv_nxt[slot_r]   = 10'd0;
            end else begin
              ev_valid_nxt[slot_r] = 1'b0;
            end
          end
        end else if (dec_eos) begin
          gen     = can;
          gen_res = '{kind: KIND_EOS, blk: (pur_r == PUR_FLUSH) ? 32'd0 : item_r.blk,
                      rc: 10'd0, lc: 10'd0};
        end
      end
      ST_FIN: begin
        if (pend_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: q_pop = 1'b0;
    endcase
    if (gen) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = gen_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      ev_valid_r   <= '0;
      any_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      ev_valid_r   <= ev_valid_nxt;
      any_r        <= any_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pur_r      <= pur_nxt;
    slot_r     <= slot_nxt;
    scan_r     <= scan_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    ev_blk_r   <= ev_blk_nxt;
    ev_rem_r   <= ev_rem_nxt;
    ev_rcv_r   <= ev_rcv_nxt;
    lastb_r    <= lastb_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[slot_addr];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.out_block      = out_r.blk;
  assign out_ch.received_count = out_r.rc;
  assign out_ch.lost_count     = out_r.lc;
  assign out_ch.last           = out_last_r;

  always_comb begin
    status.clearing = state_r == ST_CLR;
    status.open_cnt = open_cnt;
  end

endmodule

### hw/rtl/block_assembly_window.sv
// Block assembly window top level: configuration, front end and engine.
//
// Input beats on in_ch carry an opcode (add subband or flush), a block number
// and a subband number. Result beats on out_ch carry a kind (block emitted,
// subband dropped, end of stream, error), a block number, received and lost
// counts, and last, which marks the final result caused by one input beat.
// An input beat may cause no result at all. Registers num_subbands, num_blocks
// and max_in_flight sit at byte addresses 0, 4 and 8 of the APB-style port. The
// user must write them only while the block idles, not enforced by the block.
// The front end classifies each beat and holds up to two in a queue, so the
// source can run ahead of the engine.
// An add beat that completes nothing passes through LOOK, RD, MARK and FIN; an
// error found at LOOK, or a drop, goes straight to FIN. Each emitted block is
// found by a one-entry-per-cycle scan of the window for the oldest open block;
// a completion or a flush then spends one more such scan that finds nothing
// left to emit. After reset all WINDOW * MAX_SUBBANDS entries of the subband
// memory are cleared; no input beat is accepted until the clear is done.
// When the receiver stalls, one result waits in the output register and one
// more in a holding stage; the engine then waits and the queue fills.
`include "block_assembly_window_macros.svh"
module block_assembly_window import blkaw_pkg::*; #(
  parameter int WINDOW       = WINDOW_DEF,
  parameter int MAX_SUBBANDS = MAX_SUBBANDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  blkaw_in_if.sink    in_ch,
  blkaw_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  status_t back_st;

  blkaw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blkaw_front #(
    .WINDOW       (WINDOW),
    .MAX_SUBBANDS (MAX_SUBBANDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .hold    (back_st.clearing),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  blkaw_back #(
    .WINDOW       (WINDOW),
    .MAX_SUBBANDS (MAX_SUBBANDS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .status  (back_st)
  );

  `BAW_ASSERT_IMP(a_clear_no_result, back_st.clearing, !out_ch.valid, "result during clear")
  `BAW_ASSERT_IMP(a_clear_no_accept, back_st.clearing, !in_ch.ready, "input taken during clear")
  `BAW_ASSERT_IMP(a_open_bound, 1'b1, back_st.open_cnt <= 7'(WINDOW), "window overfilled")
  `BAW_ASSERT_NXT(a_pop_needs_item, q_pop, !back_st.clearing, "queue popped at clear")

endmodule

### tb/sv/block_assembly_window_checker.sv
// Checker for the block assembly window: predicts results per accepted beat and compares.
module block_assembly_window_checker import blkaw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  blkaw_in_if         in_ch,
  blkaw_out_if        out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = WINDOW_DEF;
  localparam int MAXSB = MAX_SUBBANDS_DEF;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] blk;
    logic [9:0]  rc;
    logic [9:0]  lc;
    logic        last;
  } block_result_t;

  block_result_t    expected_results[$];
  bit               slot_open [SLOTS];
  bit [31:0]        slot_blk [SLOTS];
  bit [9:0]         slot_rem [SLOTS];
  bit [MAXSB-1:0]   slot_map [SLOTS];
  bit               emitted_any;
  bit [31:0]        emitted_last;
  bit [9:0]         ns_reg;
  bit [31:0]        nb_reg;
  bit [3:0]         mif_reg;

  assign pending = expected_results.size();

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic note_result(kind_t k, bit [31:0] b, bit [9:0] rc, bit [9:0] lc, inout int n);
    if (n < 10) begin
      expected_results.insert(expected_results.size(), '{k, b, rc, lc, 1'b0});
      n++;
    end
  endtask

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_open[i] && (best < 0 || slot_blk[i] < slot_blk[best])) best = i;
    return best;
  endfunction

  task automatic release_slot(int s, inout int n);
    note_result(KIND_EMIT, slot_blk[s], 10'($countones(slot_map[s])), slot_rem[s], n);
    slot_open[s] = 1'b0;
    emitted_any = 1'b1;
    emitted_last = slot_blk[s];
  endtask

  task automatic assemble_beat(logic op, logic [31:0] blk, logic [8:0] sb);
    int n, s, o;
    int unsigned ns_eff, open_cnt, cap;
    bit drop, ok;
    n = 0;
    s = -1;
    ok = 1'b1;
    if (op == OP_FLUSH) begin
      o = oldest_slot();
      while (o >= 0) begin
        release_slot(o, n);
        o = oldest_slot();
      end
      note_result(KIND_EOS, 32'd0, 10'd0, 10'd0, n);
    end else begin
      ns_eff = (ns_reg > MAXSB) ? MAXSB : ns_reg;
      drop = (mif_reg != 0);
      for (int i = 0; i < SLOTS; i++)
        if (slot_open[i] && slot_blk[i] == blk) s = i;
      if (nb_reg != 0 && blk >= nb_reg) begin
        note_result(KIND_ERR, blk, 10'd0, 10'd0, n);
      end else if (s < 0 && emitted_any && blk <= emitted_last) begin
        note_result(drop ? KIND_DROP : KIND_ERR, blk, 10'd0, 10'd0, n);
      end else if (sb >= ns_eff) begin
        note_result(KIND_ERR, blk, 10'd0, 10'd0, n);
      end else begin
        if (s < 0) begin
          open_cnt = 0;
          for (int i = 0; i < SLOTS; i++) open_cnt += slot_open[i];
          cap = SLOTS;
          if (drop && mif_reg < cap) cap = mif_reg;
          if (open_cnt >= cap) begin
            if (!drop) begin
              note_result(KIND_ERR, blk, 10'd0, 10'd0, n);
              ok = 1'b0;
            end else begin
              release_slot(oldest_slot(), n);
            end
          end
          if (ok) begin
            for (int i = 0; i < SLOTS && s < 0; i++)
              if (!slot_open[i]) s = i;
            if (s < 0) begin
              note_result(KIND_ERR, blk, 10'd0, 10'd0, n);
              ok = 1'b0;
            end else begin
              slot_open[s] = 1'b1;
              slot_blk[s] = blk;
              slot_rem[s] = 10'(ns_eff);
              slot_map[s] = '0;
            end
          end
        end
        if (ok) begin
          if (slot_map[s][sb]) begin
            note_result(KIND_ERR, blk, 10'd0, 10'd0, n);
          end else begin
            slot_map[s][sb] = 1'b1;
            if (slot_rem[s] > 0) slot_rem[s]--;
            if (slot_rem[s] == 0) begin
              o = oldest_slot();
              while (o >= 0 && slot_blk[o] <= blk) begin
                release_slot(o, n);
                o = oldest_slot();
              end
              if (nb_reg != 0 && blk == nb_reg - 1) note_result(KIND_EOS, blk, 10'd0, 10'd0, n);
            end
          end
        end
      end
    end
    if (n > 0) expected_results[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    block_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < SLOTS; i++) slot_open[i] = 1'b0;
      emitted_any = 1'b0;
      emitted_last = '0;
      ns_reg = 10'd512;
      nb_reg = 32'd0;
      mif_reg = 4'd8;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_NUM_SUBBANDS:  ns_reg = pwdata[9:0];
          REG_NUM_BLOCKS:    nb_reg = pwdata;
          REG_MAX_IN_FLIGHT: mif_reg = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result block", out_ch.out_block, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
          if (out_ch.out_block !== want.blk) report_mismatch("out_block", out_ch.out_block, want.blk);
          if (out_ch.received_count !== want.rc)
            report_mismatch("received_count", 32'(out_ch.received_count), 32'(want.rc));
          if (out_ch.lost_count !== want.lc)
            report_mismatch("lost_count", 32'(out_ch.lost_count), 32'(want.lc));
          if (out_ch.last !== want.last)
            report_mismatch("last", 32'(out_ch.last), 32'(want.last));
        end
      end
      if (in_ch.valid && in_ch.ready)
        assemble_beat(in_ch.opcode, in_ch.block_index, in_ch.subband_index);
    end
  end

  initial begin
    fail_count = 0;
    result_count = 0;
  end
endmodule

### tb/sv/block_assembly_window_tb.sv
// Top of the block assembly window testbench: clock, reset, stimulus, stalls and verdict.
module block_assembly_window_tb;
  import blkaw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, result_count;
  int          beats_sent, burst_left, quiet_cycles, phase_count;
  int unsigned stall_cycle;
  int unsigned cur_ns, base_blk;

  blkaw_in_if  in_ch ();
  blkaw_out_if out_ch ();

  block_assembly_window DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  block_assembly_window_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_cycle <= 0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[8:7])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (stall_cycle[4:0] < 5'd6);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int unsigned ns, int unsigned nb, int unsigned mif);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    write_reg(REG_NUM_SUBBANDS, ns);
    write_reg(REG_NUM_BLOCKS, nb);
    write_reg(REG_MAX_IN_FLIGHT, mif);
    cur_ns = (ns > 512) ? 512 : ns;
    phase_count++;
  endtask

  task automatic send_beat(logic op, logic [31:0] blk, logic [8:0] sb);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.block_index <= blk;
    in_ch.subband_index <= sb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic random_beat();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_beat(OP_FLUSH, $urandom, 9'($urandom));
    end else if (pick < 14) begin
      send_beat(OP_ADD, base_blk + $urandom_range(0, 14) - 3, 9'($urandom));
    end else begin
      send_beat(OP_ADD, base_blk + $urandom_range(0, 7), 9'($urandom_range(0, cur_ns - 1)));
    end
    if ($urandom_range(0, 7) == 0) base_blk++;
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.block_index = '0;
    in_ch.subband_index = '0;
    beats_sent = 0;
    burst_left = 0;
    phase_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: completion, duplicate, bad subband, late drop, eviction, flush.
    configure(4, 0, 8);
    for (int i = 0; i < 4; i++) send_beat(OP_ADD, 0, 9'(i));
    send_beat(OP_ADD, 1, 0);
    send_beat(OP_ADD, 1, 0);
    send_beat(OP_ADD, 1, 511);
    send_beat(OP_ADD, 0, 2);
    for (int b = 2; b <= 9; b++) send_beat(OP_ADD, b, 1);
    send_beat(OP_FLUSH, 0, 0);
    // With dropping off, late beats and window overflow are errors.
    configure(1023, 0, 0);
    send_beat(OP_ADD, 3, 0);
    for (int b = 20; b <= 28; b++) send_beat(OP_ADD, b, 511);
    send_beat(OP_FLUSH, 0, 0);
    // Out-of-range blocks and the final block of the stream.
    configure(1, 40, 15);
    send_beat(OP_ADD, 32'hFFFF_FFFF, 0);
    send_beat(OP_ADD, 32'h8000_0000, 0);
    send_beat(OP_ADD, 39, 0);
    configure(2, 32'hFFFF_FFFF, 1);
    send_beat(OP_ADD, 32'hFFFF_FFFF, 0);
    base_blk = 40;

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure(3, 0, 8);
        1: configure(5, 0, 1);
        2: configure(2, 0, 0);
        3: configure(16, base_blk + 30, 3);
        4: configure(512, 0, 8);
        5: configure(1, base_blk + 20, 15);
        default: configure(1023, 0, 4);
      endcase
      for (int k = 0; k < 55; k++) random_beat();
      send_beat(OP_FLUSH, 0, 0);
    end

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("Run covered %0d input beats and %0d result beats over %0d register settings.",
             beats_sent, result_count, phase_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
